### rtl/core/spatial_vector_alu_defines.svh
// Assertion helpers for the spatial vector ALU.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SPATIAL_VECTOR_ALU_DEFINES_SVH
`define SPATIAL_VECTOR_ALU_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVALU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svalu: same-cycle pipeline check failed");

// Consequent must hold in the cycle after the antecedent.
`define SVALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svalu: next-cycle pipeline check failed");

`endif

### rtl/core/svalu_pkg.sv
package svalu_pkg;

  localparam int VEC_BITS      = 63;
  localparam int SCALE_BITS    = 21;
  localparam int DOT_BITS      = 28;
  localparam int ACTION_BITS   = 3;
  localparam int LANES         = 6;
  localparam int SLOTS         = 4;
  localparam int IN_DATA_BITS  = 280;
  localparam int OUT_DATA_BITS = 160;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 3'd0,
    ACT_SUB    = 3'd1,
    ACT_SCALE  = 3'd2,
    ACT_MCROSS = 3'd3,
    ACT_FCROSS = 3'd4,
    ACT_DOT    = 3'd5
  } action_t;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

### rtl/core/spatial_vector_alu.sv
// Spatial vector ALU: a four-stage pipeline that takes one pair of 6-D spatial
// vectors (angular and linear 3-vectors of signed fixed-point components) with
// a scalar and an action per transfer, and returns one result per transfer:
// sum, difference, first vector times the scalar, motion cross product,
// force-by-force cross product, or the dot product. It accepts one item every
// clock when the output is not stalled, and each result passes through the
// four registered stages in order; the rate is set by those stages
// (operand routing, a bank of 24 signed multipliers, lane accumulation,
// floor/saturate), each of which takes a new item whenever the stage after it
// moves or is empty, so bubbles close up under back-pressure. Products are
// kept exact, summed, then floored to FRACTION_BITS; vector components clip to
// the COMPONENT_BITS range and raise the saturated flag, and the dot product
// clips to 28 bits. Action codes 6 and 7 give an all-zero result.
module spatial_vector_alu #(
  parameter int COMPONENT_BITS = 21,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // action
  input  logic [svalu_pkg::ACTION_BITS-1:0]       in_tuser,
  // first_angular, first_linear, second_angular, second_linear, scale_factor, zero pad
  input  logic [svalu_pkg::IN_DATA_BITS-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // saturated
  output logic                                    out_tuser,
  // result_angular, result_linear, dot_value, zero pad
  output logic [svalu_pkg::OUT_DATA_BITS-1:0]     out_tdata
);
  import svalu_pkg::*;

  localparam int C  = COMPONENT_BITS;
  localparam int SB = SCALE_BITS;
  localparam int LW = C + SB + 2;

  // Field offsets inside in_tdata.
  localparam int FA_LO = 0;
  localparam int FL_LO = FA_LO + VEC_BITS;
  localparam int SA_LO = FL_LO + VEC_BITS;
  localparam int SL_LO = SA_LO + VEC_BITS;
  localparam int SF_LO = SL_LO + VEC_BITS;

  logic      v1_r, v2_r, v3_r, out_valid_r;
  logic      v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  stage_en_t en;

  logic signed [C-1:0]  a_r       [LANES][SLOTS];
  logic signed [SB-1:0] b_r       [LANES][SLOTS];
  logic                 neg_r     [LANES][SLOTS];
  logic signed [C:0]    addsub1_r [LANES];
  action_t              action1_r;
  logic signed [LW-1:0] lane_r    [LANES];
  logic signed [C:0]    addsub3_r [LANES];
  action_t              action3_r;

  logic [VEC_BITS-1:0]        res_ang_r;
  logic [VEC_BITS-1:0]        res_lin_r;
  logic signed [DOT_BITS-1:0] dot_r;
  logic                       sat_r;

  // A stage loads when it is empty or its content moves on in the same cycle.
  assign en.s4 = !out_valid_r || out_tready;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_tready = en.s1;

  // Advance valid bits with their stage; hold them while the stage is stalled.
  always_comb begin
    v1_nxt        = en.s1 ? in_tvalid : v1_r;
    v2_nxt        = en.s2 ? v1_r      : v2_r;
    v3_nxt        = en.s3 ? v2_r      : v3_r;
    out_valid_nxt = en.s4 ? v3_r      : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: unpack, route operands into lanes, form sums and differences.
  svalu_opsel #(
    .C (C)
  ) u_opsel (
    .clk            (clk),
    .en             (en),
    .action         (in_tuser),
    .first_angular  (in_tdata[FA_LO +: VEC_BITS]),
    .first_linear   (in_tdata[FL_LO +: VEC_BITS]),
    .second_angular (in_tdata[SA_LO +: VEC_BITS]),
    .second_linear  (in_tdata[SL_LO +: VEC_BITS]),
    .scale_factor   (in_tdata[SF_LO +: SB]),
    .a_r            (a_r),
    .b_r            (b_r),
    .neg_r          (neg_r),
    .addsub_r       (addsub1_r),
    .action_r       (action1_r)
  );

  // Stages 2 and 3: products, then signed lane sums.
  svalu_mac #(
    .C (C)
  ) u_mac (
    .clk       (clk),
    .en        (en),
    .a_r       (a_r),
    .b_r       (b_r),
    .neg_r     (neg_r),
    .addsub_r  (addsub1_r),
    .action_r  (action1_r),
    .lane_r    (lane_r),
    .addsub3_r (addsub3_r),
    .action3_r (action3_r)
  );

  // Stage 4: floor, clip, pack; this is also the output register.
  svalu_round #(
    .C (C),
    .F (FRACTION_BITS)
  ) u_round (
    .clk       (clk),
    .en        (en),
    .lane_r    (lane_r),
    .addsub_r  (addsub3_r),
    .action_r  (action3_r),
    .res_ang_r (res_ang_r),
    .res_lin_r (res_lin_r),
    .dot_r     (dot_r),
    .sat_r     (sat_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = sat_r;
  assign out_tdata  = {{(OUT_DATA_BITS-2*VEC_BITS-DOT_BITS){1'b0}},
                       dot_r, res_lin_r, res_ang_r};

`include "spatial_vector_alu_defines.svh"

  // A full pipeline with a stalled output must refuse new input.
  `SVALU_ASSERT_NOW(a_full_stall_blocks_input, v1_r && v2_r && v3_r && out_valid_r && !out_tready, !in_tready)
  // An item in the last inner stage that may advance shows up at the output.
  `SVALU_ASSERT_NEXT(a_stage3_reaches_output, v3_r && en.s4, out_tvalid)
  // A stalled first stage keeps its item.
  `SVALU_ASSERT_NEXT(a_stage1_holds_on_stall, v1_r && !en.s2, v1_r)

endmodule

### rtl/core/svalu_opsel.sv
module svalu_opsel #(
  parameter int C = 21
) (
  input  logic                                clk,
  input  svalu_pkg::stage_en_t                en,
  input  logic [svalu_pkg::ACTION_BITS-1:0]   action,
  input  logic [svalu_pkg::VEC_BITS-1:0]      first_angular,
  input  logic [svalu_pkg::VEC_BITS-1:0]      first_linear,
  input  logic [svalu_pkg::VEC_BITS-1:0]      second_angular,
  input  logic [svalu_pkg::VEC_BITS-1:0]      second_linear,
  input  logic signed [svalu_pkg::SCALE_BITS-1:0] scale_factor,
  output logic signed [C-1:0]                 a_r      [svalu_pkg::LANES][svalu_pkg::SLOTS],
  output logic signed [svalu_pkg::SCALE_BITS-1:0] b_r  [svalu_pkg::LANES][svalu_pkg::SLOTS],
  output logic                                neg_r    [svalu_pkg::LANES][svalu_pkg::SLOTS],
  output logic signed [C:0]                   addsub_r [svalu_pkg::LANES],
  output svalu_pkg::action_t                  action_r
);
  import svalu_pkg::*;

  localparam int SB = SCALE_BITS;

  logic signed [C-1:0]  w1 [3];
  logic signed [C-1:0]  v1 [3];
  logic signed [C-1:0]  w2 [3];
  logic signed [C-1:0]  v2 [3];
  logic signed [C-1:0]  a_nxt      [LANES][SLOTS];
  logic signed [SB-1:0] b_nxt      [LANES][SLOTS];
  logic                 neg_nxt    [LANES][SLOTS];
  logic signed [C:0]    addsub_nxt [LANES];
  action_t              act;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w1[i] = first_angular[i*C +: C];
      v1[i] = first_linear[i*C +: C];
      w2[i] = second_angular[i*C +: C];
      v2[i] = second_linear[i*C +: C];
    end
  end

  assign act = action_t'(action);

  // Route operand pairs into six lanes of four product slots each.
  always_comb begin
    int j;
    int k;
    for (int l = 0; l < LANES; l++) begin
      addsub_nxt[l] = '0;
      for (int s = 0; s < SLOTS; s++) begin
        a_nxt[l][s]   = '0;
        b_nxt[l][s]   = '0;
        neg_nxt[l][s] = 1'b0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      case (act)
        ACT_ADD: begin
          addsub_nxt[i]   = (C+1)'(w1[i]) + (C+1)'(w2[i]);
          addsub_nxt[3+i] = (C+1)'(v1[i]) + (C+1)'(v2[i]);
        end
        ACT_SUB: begin
          addsub_nxt[i]   = (C+1)'(w1[i]) - (C+1)'(w2[i]);
          addsub_nxt[3+i] = (C+1)'(v1[i]) - (C+1)'(v2[i]);
        end
        ACT_SCALE: begin
          a_nxt[i][0]   = w1[i]; b_nxt[i][0]   = scale_factor;
          a_nxt[3+i][0] = v1[i]; b_nxt[3+i][0] = scale_factor;
        end
        ACT_MCROSS: begin
          a_nxt[i][0] = w1[j]; b_nxt[i][0] = SB'(w2[k]);
          a_nxt[i][1] = w1[k]; b_nxt[i][1] = SB'(w2[j]); neg_nxt[i][1] = 1'b1;
          a_nxt[3+i][0] = v1[j]; b_nxt[3+i][0] = SB'(w2[k]);
          a_nxt[3+i][1] = v1[k]; b_nxt[3+i][1] = SB'(w2[j]); neg_nxt[3+i][1] = 1'b1;
          a_nxt[3+i][2] = w1[j]; b_nxt[3+i][2] = SB'(v2[k]);
          a_nxt[3+i][3] = w1[k]; b_nxt[3+i][3] = SB'(v2[j]); neg_nxt[3+i][3] = 1'b1;
        end
        ACT_FCROSS: begin
          a_nxt[i][0] = w1[j]; b_nxt[i][0] = SB'(w2[k]);
          a_nxt[i][1] = w1[k]; b_nxt[i][1] = SB'(w2[j]); neg_nxt[i][1] = 1'b1;
          a_nxt[i][2] = v1[j]; b_nxt[i][2] = SB'(v2[k]);
          a_nxt[i][3] = v1[k]; b_nxt[i][3] = SB'(v2[j]); neg_nxt[i][3] = 1'b1;
          a_nxt[3+i][0] = w1[j]; b_nxt[3+i][0] = SB'(v2[k]);
          a_nxt[3+i][1] = w1[k]; b_nxt[3+i][1] = SB'(v2[j]); neg_nxt[3+i][1] = 1'b1;
          a_nxt[3+i][2] = v1[k]; b_nxt[3+i][2] = SB'(w2[j]); neg_nxt[3+i][2] = 1'b1;
          a_nxt[3+i][3] = v1[j]; b_nxt[3+i][3] = SB'(w2[k]);
        end
        ACT_DOT: begin
          a_nxt[i][0]   = w1[i]; b_nxt[i][0]   = SB'(w2[i]);
          a_nxt[3+i][0] = v1[i]; b_nxt[3+i][0] = SB'(v2[i]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      neg_r    <= neg_nxt;
      addsub_r <= addsub_nxt;
      action_r <= act;
    end
  end

endmodule

### rtl/core/svalu_mac.sv
module svalu_mac #(
  parameter int C = 21
) (
  input  logic                                clk,
  input  svalu_pkg::stage_en_t                en,
  input  logic signed [C-1:0]                 a_r      [svalu_pkg::LANES][svalu_pkg::SLOTS],
  input  logic signed [svalu_pkg::SCALE_BITS-1:0] b_r  [svalu_pkg::LANES][svalu_pkg::SLOTS],
  input  logic                                neg_r    [svalu_pkg::LANES][svalu_pkg::SLOTS],
  input  logic signed [C:0]                   addsub_r [svalu_pkg::LANES],
  input  svalu_pkg::action_t                  action_r,
  output logic signed [C+svalu_pkg::SCALE_BITS+1:0] lane_r [svalu_pkg::LANES],
  output logic signed [C:0]                   addsub3_r [svalu_pkg::LANES],
  output svalu_pkg::action_t                  action3_r
);
  import svalu_pkg::*;

  localparam int PW = C + SCALE_BITS;
  localparam int LW = PW + 2;

  logic signed [PW-1:0] prod_r    [LANES][SLOTS];
  logic                 neg2_r    [LANES][SLOTS];
  logic signed [C:0]    addsub2_r [LANES];
  action_t              action2_r;
  logic signed [LW-1:0] lane_nxt  [LANES];

  // Multiply stage: one registered product per slot.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int l = 0; l < LANES; l++) begin
        for (int s = 0; s < SLOTS; s++) begin
          prod_r[l][s] <= PW'(a_r[l][s]) * PW'(b_r[l][s]);
        end
      end
      neg2_r    <= neg_r;
      addsub2_r <= addsub_r;
      action2_r <= action_r;
    end
  end

  // Accumulate the signed products of each lane at full precision.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_nxt[l] = '0;
      for (int s = 0; s < SLOTS; s++) begin
        if (neg2_r[l][s]) begin
          lane_nxt[l] = lane_nxt[l] - LW'(prod_r[l][s]);
        end else begin
          lane_nxt[l] = lane_nxt[l] + LW'(prod_r[l][s]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      lane_r    <= lane_nxt;
      addsub3_r <= addsub2_r;
      action3_r <= action2_r;
    end
  end

endmodule

### rtl/core/svalu_round.sv
module svalu_round #(
  parameter int C = 21,
  parameter int F = 16
) (
  input  logic                                clk,
  input  svalu_pkg::stage_en_t                en,
  input  logic signed [C+svalu_pkg::SCALE_BITS+1:0] lane_r [svalu_pkg::LANES],
  input  logic signed [C:0]                   addsub_r [svalu_pkg::LANES],
  input  svalu_pkg::action_t                  action_r,
  output logic [svalu_pkg::VEC_BITS-1:0]      res_ang_r,
  output logic [svalu_pkg::VEC_BITS-1:0]      res_lin_r,
  output logic signed [svalu_pkg::DOT_BITS-1:0] dot_r,
  output logic                                sat_r
);
  import svalu_pkg::*;

  localparam int LW = C + SCALE_BITS + 2;
  localparam int DW = LW + 3;
  localparam logic signed [LW-1:0] CMAX = {{(LW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [LW-1:0] CMIN = {{(LW-C+1){1'b1}}, {(C-1){1'b0}}};
  localparam logic signed [DW-1:0] DMAX = {{(DW-DOT_BITS+1){1'b0}}, {(DOT_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {{(DW-DOT_BITS+1){1'b1}}, {(DOT_BITS-1){1'b0}}};

  logic signed [LW-1:0]       val;
  logic signed [C-1:0]        comp;
  logic [VEC_BITS-1:0]        ang_nxt;
  logic [VEC_BITS-1:0]        lin_nxt;
  logic                       sat_nxt;
  logic signed [DW-1:0]       dsum;
  logic signed [DW-1:0]       dsh;
  logic signed [DOT_BITS-1:0] dot_nxt;
  logic                       is_vec;
  logic                       is_addsub;

  assign is_addsub = (action_r == ACT_ADD) || (action_r == ACT_SUB);
  assign is_vec    = is_addsub || (action_r == ACT_SCALE) ||
                     (action_r == ACT_MCROSS) || (action_r == ACT_FCROSS);

  // Floor to the component grid, clip and pack.
  always_comb begin
    ang_nxt = '0;
    lin_nxt = '0;
    sat_nxt = 1'b0;
    val     = '0;
    comp    = '0;
    for (int l = 0; l < LANES; l++) begin
      if (is_addsub) begin
        val = LW'(addsub_r[l]);
      end else begin
        val = lane_r[l] >>> F;
      end
      if (val > CMAX) begin
        comp = C'(CMAX);
        sat_nxt = sat_nxt | is_vec;
      end else if (val < CMIN) begin
        comp = C'(CMIN);
        sat_nxt = sat_nxt | is_vec;
      end else begin
        comp = C'(val);
      end
      if (is_vec) begin
        if (l < 3) begin
          ang_nxt[(l%3)*C +: C] = comp;
        end else begin
          lin_nxt[(l%3)*C +: C] = comp;
        end
      end
    end
  end

  // Dot product: each lane holds one product, so the lane sums add up to it.
  always_comb begin
    dsum = '0;
    for (int l = 0; l < LANES; l++) begin
      dsum = dsum + DW'(lane_r[l]);
    end
    dsh = dsum >>> F;
    if (action_r != ACT_DOT) begin
      dot_nxt = '0;
    end else if (dsh > DMAX) begin
      dot_nxt = DOT_BITS'(DMAX);
    end else if (dsh < DMIN) begin
      dot_nxt = DOT_BITS'(DMIN);
    end else begin
      dot_nxt = DOT_BITS'(dsh);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_ang_r <= ang_nxt;
      res_lin_r <= lin_nxt;
      dot_r     <= dot_nxt;
      sat_r     <= sat_nxt;
    end
  end

endmodule
